// File: sv/bsfa_pkg.sv
// Shared types and constants for the byte stack with frame access.
// Holds the request and result structs, opcode and error codes, and the lane control struct.
// No dependencies.
package bsfa_pkg;

    localparam int DATA_W = 64;
    localparam int PTR_W  = 12;
    localparam int OFF_W  = 12;
    localparam int SIZE_W = 4;
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    localparam logic [7:0]        FILL_BYTE  = 8'hcd;
    localparam logic [SIZE_W-1:0] PEEK_BYTES = 4'd8;

    typedef enum logic [2:0] {
        OP_PUSH       = 3'd0,
        OP_POP        = 3'd1,
        OP_PEEK       = 3'd2,
        OP_FRAME_WR   = 3'd3,
        OP_FRAME_RD   = 3'd4,
        OP_READ_BELOW = 3'd5,
        OP_SET_BASE   = 3'd6,
        OP_SET_SP     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2
    } t_err;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [SIZE_W-1:0] size_bytes;
        logic [DATA_W-1:0] write_data;
        logic [OFF_W-1:0]  byte_offset;
        logic [PTR_W-1:0]  new_pointer;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [PTR_W-1:0]  stack_pointer;
        logic [PTR_W-1:0]  base_pointer;
        logic [1:0]        error_code;
    } t_rsp;

    // Per-access control shared by all byte lanes
    typedef struct packed {
        logic              wr;
        logic              fill;
        logic [LANE_W-1:0] lo;
        logic [SIZE_W-1:0] nbytes;
    } t_lane_req;

endpackage

// File: sv/bsfa_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module bsfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bsfa_lane.sv
// One byte lane of the stack memory: picks its row, byte and write enable for an access.
// Depends on bsfa_pkg and bsfa_ram.
module bsfa_lane #(
    parameter int LANE  = 0,
    parameter int DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  bsfa_pkg::t_lane_req         i_ctl,
    input  logic [$clog2(DEPTH)-1:0]    i_row,
    input  logic [$clog2(DEPTH)-1:0]    i_row_next,
    input  logic [bsfa_pkg::DATA_W-1:0] i_wdata,
    output logic [7:0]                  o_rdata
);

    localparam logic [bsfa_pkg::LANE_W-1:0] LANE_ID = bsfa_pkg::LANE_W'(LANE);

    logic [bsfa_pkg::LANE_W-1:0] byte_idx;
    logic                        active;
    logic [$clog2(DEPTH)-1:0]    row;
    logic [7:0]                  wbyte;

    always_comb begin
        // position of this lane's byte within the access
        byte_idx = LANE_ID - i_ctl.lo;
        active   = {1'b0, byte_idx} < i_ctl.nbytes;
        // lanes below the start lane wrap into the next row
        row      = (LANE_ID >= i_ctl.lo) ? i_row : i_row_next;
        wbyte    = i_ctl.fill ? bsfa_pkg::FILL_BYTE : i_wdata[8*byte_idx +: 8];
    end

    bsfa_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_en && i_ctl.wr && active),
        .i_waddr (row),
        .i_wdata (wbyte),
        .i_raddr (row),
        .o_rdata (o_rdata)
    );

endmodule

// File: sv/bsfa_merge.sv
// Merge stage: rotates the lane bytes into little-endian order and zero-extends.
// Depends on bsfa_pkg.
module bsfa_merge (
    input  logic [7:0]                  i_lane_data [bsfa_pkg::LANES],
    input  logic                        i_rd,
    input  logic [bsfa_pkg::LANE_W-1:0] i_lo,
    input  logic [bsfa_pkg::SIZE_W-1:0] i_nbytes,
    output logic [bsfa_pkg::DATA_W-1:0] o_data
);

    always_comb begin
        logic [bsfa_pkg::LANE_W-1:0] idx;
        o_data = '0;
        for (int i = 0; i < bsfa_pkg::LANES; i++) begin
            idx = i_lo + bsfa_pkg::LANE_W'(i);
            if (i_rd && (bsfa_pkg::SIZE_W'(i) < i_nbytes)) begin
                o_data[8*i +: 8] = i_lane_data[idx];
            end
        end
    end

endmodule

// File: sv/byte_stack_with_frame_access.sv
// Byte stack with frame access: top level.
// Depends on bsfa_pkg, bsfa_lane, bsfa_merge.
//
// Usage:
//   A request (i_req) is taken at a rising edge where start is high and busy is low.
//   Opcodes: push, pop, peek top 8 bytes, frame write/read at base + offset,
//   read at stack pointer - offset, set base, set stack pointer.
//   Each request gives exactly one result on o_rsp, marked by o_valid for one
//   cycle; the receiver cannot stall it. The result is registered in the s1
//   stage and then in the output register.
//   Throughput: one request per cycle while busy is low. Memory is eight
//   byte-wide lanes, each STACK_BYTES/8 deep with one read and one write
//   port; a request touches each lane at most once, and pointers update at
//   the request edge, so the next request sees them and the written bytes at once.
//   A failing request (underflow, overflow, out of range) changes nothing,
//   returns zero read data and reports the error code.
//   i_cfg_we/i_cfg_wdata write the debug fill enable; write it while idle.
//   Reset (synchronous, active low) clears both pointers, the fill enable and
//   the result strobe; busy is high during reset. Memory contents are not
//   cleared. STACK_BYTES must be a multiple of 8.
module byte_stack_with_frame_access #(
    parameter int STACK_BYTES      = 2048,
    parameter int MAX_ACCESS_BYTES = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  bsfa_pkg::t_req i_req,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    output logic           o_valid,
    output bsfa_pkg::t_rsp o_rsp
);

    localparam int PW    = $clog2(STACK_BYTES + 1);
    localparam int EW    = ((PW > bsfa_pkg::OFF_W) ? PW : bsfa_pkg::OFF_W) + 2;
    localparam int DEPTH = STACK_BYTES / bsfa_pkg::LANES;
    localparam int RW    = $clog2(DEPTH);

    localparam logic [EW-1:0] SB_E = EW'(STACK_BYTES);
    localparam logic [bsfa_pkg::SIZE_W-1:0] MAX_SZ = bsfa_pkg::SIZE_W'(MAX_ACCESS_BYTES);

    logic [PW-1:0] r_sp, n_sp;
    logic [PW-1:0] r_fb, n_fb;
    logic          r_fill_en;
    logic          r_busy;

    // stage after memory read
    logic                        r_s1_valid;
    logic                        r_s1_rd;
    logic [bsfa_pkg::LANE_W-1:0] r_s1_lo;
    logic [bsfa_pkg::SIZE_W-1:0] r_s1_n;
    logic [1:0]                  r_s1_err;
    logic [PW-1:0]               r_s1_sp;
    logic [PW-1:0]               r_s1_fb;

    logic           r_out_valid;
    bsfa_pkg::t_rsp r_out_rsp;

    logic                accepted;
    logic                size_ok;
    logic [EW-1:0]       sp_e, fb_e, off_e, sz_e, np_e;
    logic [EW-1:0]       addr;
    logic [EW-1:0]       frame_addr;
    logic [1:0]          err;
    logic                do_rd;
    logic [bsfa_pkg::SIZE_W-1:0] nbytes;
    bsfa_pkg::t_lane_req lane_ctl;
    logic [RW-1:0]       row, row_next;
    logic [7:0]          lane_data [bsfa_pkg::LANES];
    logic [bsfa_pkg::DATA_W-1:0] merged;

    assign accepted = start && !busy;
    assign busy     = r_busy;

    always_comb begin
        size_ok    = (i_req.size_bytes != '0) && (i_req.size_bytes <= MAX_SZ);
        sp_e       = EW'(r_sp);
        fb_e       = EW'(r_fb);
        off_e      = EW'(i_req.byte_offset);
        sz_e       = EW'(i_req.size_bytes);
        np_e       = EW'(i_req.new_pointer);
        frame_addr = fb_e + off_e;

        n_sp          = r_sp;
        n_fb          = r_fb;
        err           = bsfa_pkg::ERR_OK;
        do_rd         = 1'b0;
        addr          = sp_e;
        nbytes        = i_req.size_bytes;
        lane_ctl.wr   = 1'b0;
        lane_ctl.fill = 1'b0;

        case (bsfa_pkg::t_op'(i_req.opcode))
            bsfa_pkg::OP_PUSH: begin
                if (!size_ok || (sp_e + sz_e > SB_E)) begin
                    err = bsfa_pkg::ERR_OVER;
                end else begin
                    lane_ctl.wr = 1'b1;
                    n_sp        = PW'(sp_e + sz_e);
                end
            end
            bsfa_pkg::OP_POP: begin
                if (!size_ok) begin
                    err = bsfa_pkg::ERR_OVER;
                end else if (sz_e > sp_e) begin
                    err = bsfa_pkg::ERR_UNDER;
                end else begin
                    addr          = sp_e - sz_e;
                    n_sp          = PW'(addr);
                    do_rd         = 1'b1;
                    // read-first memory returns old bytes while the fill lands
                    lane_ctl.wr   = r_fill_en;
                    lane_ctl.fill = 1'b1;
                end
            end
            bsfa_pkg::OP_PEEK: begin
                nbytes = bsfa_pkg::PEEK_BYTES;
                if (sp_e < EW'(bsfa_pkg::PEEK_BYTES)) begin
                    err = bsfa_pkg::ERR_UNDER;
                end else begin
                    addr  = sp_e - EW'(bsfa_pkg::PEEK_BYTES);
                    do_rd = 1'b1;
                end
            end
            bsfa_pkg::OP_FRAME_WR, bsfa_pkg::OP_FRAME_RD: begin
                addr = frame_addr;
                if (!size_ok || (frame_addr + sz_e > SB_E)) begin
                    err = bsfa_pkg::ERR_OVER;
                end else if (i_req.opcode == bsfa_pkg::OP_FRAME_WR) begin
                    lane_ctl.wr = 1'b1;
                end else begin
                    do_rd = 1'b1;
                end
            end
            bsfa_pkg::OP_READ_BELOW: begin
                addr = sp_e - off_e;
                if (!size_ok) begin
                    err = bsfa_pkg::ERR_OVER;
                end else if (off_e > sp_e) begin
                    err = bsfa_pkg::ERR_UNDER;
                end else if (addr + sz_e > SB_E) begin
                    err = bsfa_pkg::ERR_OVER;
                end else begin
                    do_rd = 1'b1;
                end
            end
            bsfa_pkg::OP_SET_BASE: begin
                if (np_e > SB_E) begin
                    err = bsfa_pkg::ERR_OVER;
                end else begin
                    n_fb = PW'(np_e);
                end
            end
            bsfa_pkg::OP_SET_SP: begin
                if (np_e > SB_E) begin
                    err = bsfa_pkg::ERR_OVER;
                end else begin
                    n_sp = PW'(np_e);
                end
            end
            default: begin
                err = bsfa_pkg::ERR_OVER;
            end
        endcase

        lane_ctl.lo     = addr[bsfa_pkg::LANE_W-1:0];
        lane_ctl.nbytes = nbytes;
        row             = addr[RW+bsfa_pkg::LANE_W-1:bsfa_pkg::LANE_W];
        row_next        = row + RW'(1);
    end

    for (genvar g = 0; g < bsfa_pkg::LANES; g++) begin : g_lane
        bsfa_lane #(
            .LANE  (g),
            .DEPTH (DEPTH)
        ) u_lane (
            .i_clk      (i_clk),
            .i_en       (accepted),
            .i_ctl      (lane_ctl),
            .i_row      (row),
            .i_row_next (row_next),
            .i_wdata    (i_req.write_data),
            .o_rdata    (lane_data[g])
        );
    end

    bsfa_merge u_merge (
        .i_lane_data (lane_data),
        .i_rd        (r_s1_rd),
        .i_lo        (r_s1_lo),
        .i_nbytes    (r_s1_n),
        .o_data      (merged)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_fb        <= '0;
            r_fill_en   <= 1'b0;
            r_busy      <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= 1'b0;
            r_s1_valid  <= accepted;
            r_out_valid <= r_s1_valid;
            if (i_cfg_we) begin
                r_fill_en <= i_cfg_wdata;
            end
            if (accepted) begin
                r_sp <= n_sp;
                r_fb <= n_fb;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (accepted) begin
            r_s1_rd  <= do_rd;
            r_s1_lo  <= lane_ctl.lo;
            r_s1_n   <= nbytes;
            r_s1_err <= err;
            r_s1_sp  <= n_sp;
            r_s1_fb  <= n_fb;
        end
        if (r_s1_valid) begin
            r_out_rsp.read_data     <= merged;
            r_out_rsp.stack_pointer <= bsfa_pkg::PTR_W'(r_s1_sp);
            r_out_rsp.base_pointer  <= bsfa_pkg::PTR_W'(r_s1_fb);
            r_out_rsp.error_code    <= r_s1_err;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out_rsp;

endmodule
